[sv/v3n_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_pkg
// Types shared by the vector normalizer sequencer and its floating-point unit.
// ----------------------------------------------------------------------------
package v3n_pkg;

  // Operations of the shared floating-point unit.
  typedef enum logic [1:0] {
    OP_MUL   = 2'd0,
    OP_ADD   = 2'd1,
    OP_SQRT  = 2'd2,
    OP_RECIP = 2'd3
  } fpu_op_e;

  typedef struct packed {
    logic        start;
    fpu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

endpackage

[sv/v3n_fpu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_fpu
// Shared single-precision unit: multiply, add of non-negative operands,
// square root and reciprocal, all rounded to nearest even with subnormals.
// ----------------------------------------------------------------------------
module v3n_fpu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  v3n_pkg::fpu_req_t req_i,
  output v3n_pkg::fpu_rsp_t rsp_o
);
  import v3n_pkg::*;

  localparam logic [4:0]  IterLast = 5'd25;
  localparam logic [31:0] FpInf    = 32'h7F80_0000;

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_NORM  = 5'b00010,
    F_ITER  = 5'b00100,
    F_FIN   = 5'b01000,
    F_ROUND = 5'b10000
  } fst_e;

  // Leading zero count of a 48-bit product.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] lz;
    logic       found;
    lz    = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        lz    = 6'(47 - i);
        found = 1'b1;
      end
    end
    return lz;
  endfunction

  // Rounds a mantissa whose leading one sits at bit 47 (or lower when the
  // exponent is 1 and the value is subnormal) and packs the result.
  function automatic logic [31:0] fp_round(input logic sign, input logic signed [10:0] be,
                                           input logic [47:0] n, input logic stk);
    logic [95:0] sh_v;
    logic [47:0] n2;
    logic [23:0] m;
    logic        g;
    logic        st;
    logic        up;
    logic [7:0]  ef;
    logic [10:0] shamt;
    logic [6:0]  sc;
    logic [30:0] mag;
    shamt = 11'd1 - be;
    sh_v  = '0;
    if (be >= 11'sd255) begin
      return {sign, FpInf[30:0]};
    end
    if (be >= 11'sd1) begin
      m  = n[47:24];
      g  = n[23];
      st = (|n[22:0]) | stk;
      ef = m[23] ? be[7:0] : 8'd0;
    end else begin
      sc   = (shamt > 11'd72) ? 7'd72 : shamt[6:0];
      sh_v = {n, 48'b0} >> sc;
      n2   = sh_v[95:48];
      m    = n2[47:24];
      g    = n2[23];
      st   = (|n2[22:0]) | (|sh_v[47:0]) | stk;
      ef   = 8'd0;
    end
    up  = g & (st | m[0]);
    // A carry out of the fraction moves into the exponent field on its own.
    mag = {ef, m[22:0]} + {30'b0, up};
    return {sign, mag};
  endfunction

  fst_e               state_q;
  fpu_op_e            op_q;
  logic [4:0]         cnt_q;
  logic               done_q;
  logic [48:0]        work_q;
  logic signed [10:0] be_q;
  logic               sign_q;
  logic               stk_q;
  logic               spec_q;
  logic [29:0]        rem_q;
  logic [25:0]        root_q;
  logic [51:0]        rad_q;
  logic [23:0]        dvs_q;
  logic [31:0]        res_q;

  // Operand decode.
  logic [7:0]  ea, eb, eae, ebe;
  logic [23:0] ma, mb;
  logic [47:0] prod;
  logic        a_big;
  logic [23:0] mbig, msml;
  logic [7:0]  ebig, esml, dexp;
  logic [6:0]  dc;
  logic [95:0] al;
  logic [48:0] asum;
  logic [24:0] madj;
  logic [10:0] sbe;

  always_comb begin
    ea    = req_i.a[30:23];
    eb    = req_i.b[30:23];
    ma    = {(ea != 8'd0), req_i.a[22:0]};
    mb    = {(eb != 8'd0), req_i.b[22:0]};
    eae   = (ea == 8'd0) ? 8'd1 : ea;
    ebe   = (eb == 8'd0) ? 8'd1 : eb;
    prod  = ma * mb;
    a_big = req_i.a[30:0] >= req_i.b[30:0];
    mbig  = a_big ? ma : mb;
    msml  = a_big ? mb : ma;
    ebig  = a_big ? eae : ebe;
    esml  = a_big ? ebe : eae;
    dexp  = ebig - esml;
    dc    = (dexp > 8'd72) ? 7'd72 : dexp[6:0];
    al    = {msml, 72'b0} >> dc;
    asum  = {1'b0, mbig, 24'b0} + {1'b0, al[95:48]};
    madj  = ea[0] ? {ma, 1'b0} : {1'b0, ma};
    sbe   = 11'd62 + {3'b0, (ea - {7'b0, ea[0]}) >> 1};
  end

  // One compare and subtract per cycle, shared by square root and reciprocal.
  logic [29:0] ta, tb, tdiff, rem_n;
  logic        ge;
  logic [5:0]  lz;

  always_comb begin
    if (op_q == OP_SQRT) begin
      ta = {rem_q[27:0], rad_q[51:50]};
      tb = {2'b0, root_q, 2'b01};
    end else begin
      ta = rem_q;
      tb = {6'b0, dvs_q};
    end
    ge    = ta >= tb;
    tdiff = ta - tb;
    rem_n = ge ? tdiff : ta;
    lz    = lzc48(work_q[47:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      op_q    <= OP_MUL;
      cnt_q   <= 5'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == F_ROUND);
      case (state_q)
        F_IDLE: begin
          if (req_i.start) begin
            op_q  <= req_i.op;
            cnt_q <= IterLast;
            case (req_i.op)
              OP_MUL, OP_ADD:    state_q <= F_NORM;
              OP_SQRT, OP_RECIP: state_q <= F_ITER;
              default:           state_q <= F_IDLE;
            endcase
          end
        end
        F_ITER: begin
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            state_q <= F_FIN;
          end
        end
        F_FIN:  state_q <= F_ROUND;
        F_NORM: state_q <= F_ROUND;
        F_ROUND: begin
          state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            OP_MUL: begin
              work_q <= {1'b0, prod};
              be_q   <= $signed({3'b0, eae}) + $signed({3'b0, ebe}) - 11'sd126;
              sign_q <= req_i.a[31] ^ req_i.b[31];
              stk_q  <= 1'b0;
              spec_q <= (ea == 8'hFF) || (eb == 8'hFF);
            end
            OP_ADD: begin
              work_q <= asum;
              be_q   <= $signed({3'b0, ebig});
              sign_q <= 1'b0;
              stk_q  <= |al[47:0];
              spec_q <= (ea == 8'hFF) || (eb == 8'hFF);
            end
            OP_SQRT: begin
              rad_q  <= {1'b0, madj, 26'b0};
              rem_q  <= 30'd0;
              root_q <= 26'd0;
              be_q   <= $signed(sbe);
              sign_q <= 1'b0;
              stk_q  <= 1'b0;
              spec_q <= 1'b0;
            end
            OP_RECIP: begin
              rem_q  <= 30'h0080_0000;
              dvs_q  <= ma;
              root_q <= 26'd0;
              be_q   <= 11'sd253 - $signed({3'b0, ea});
              sign_q <= 1'b0;
              stk_q  <= 1'b0;
              spec_q <= 1'b0;
            end
            default: ;
          endcase
        end
      end
      F_ITER: begin
        rem_q  <= (op_q == OP_SQRT) ? {2'b0, rem_n[27:0]} : {rem_n[28:0], 1'b0};
        root_q <= {root_q[24:0], ge};
        rad_q  <= {rad_q[49:0], 2'b00};
      end
      F_FIN: begin
        // A remainder left over means the exact result lies beyond the last bit.
        stk_q  <= (rem_q != 30'd0);
        work_q <= root_q[25] ? {1'b0, root_q, 22'b0} : {1'b0, root_q[24:0], 23'b0};
        be_q   <= be_q + $signed({10'b0, root_q[25]})
                  + ((op_q == OP_SQRT) ? 11'sd1 : 11'sd0);
      end
      F_NORM: begin
        if (op_q == OP_MUL) begin
          work_q <= {1'b0, work_q[47:0] << lz};
          be_q   <= be_q - $signed({5'b0, lz});
        end else if (work_q[48]) begin
          work_q <= {1'b0, work_q[48:1]};
          stk_q  <= stk_q | work_q[0];
          be_q   <= be_q + 11'sd1;
        end
      end
      F_ROUND: begin
        res_q <= spec_q ? FpInf : fp_round(sign_q, be_q, work_q[47:0], stk_q);
      end
      default: ;
    endcase
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

[sv/vec3_normalize_minmax_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_normalize_minmax_unit
// Normalizes one single-precision 3-vector per item and keeps running
// per-component bounds of the results.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    comp_x/y/z_i, first_item_i
// out       output     out_valid_o / out_ready_i  norm_*_o, invalid_o, low_*_o, high_*_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_track_bounds_i
//
// An item runs as a chain of operations on one shared floating-point unit.
// The sequencer waits on each operation until the unit reports it done: three
// squares and two adds for every item; a vector that needs scaling then adds a
// square root, a reciprocal and three multiplies. A new item is taken only once
// the previous one has been written to the output register.
// Reset clears the bounds and the tracking flag. The next item is taken while
// a finished result waits; a stalled result holds the sequencer at its end.
// ----------------------------------------------------------------------------
module vec3_normalize_minmax_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] comp_x_i,
  input  logic [31:0] comp_y_i,
  input  logic [31:0] comp_z_i,
  input  logic        first_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] norm_x_o,
  output logic [31:0] norm_y_o,
  output logic [31:0] norm_z_o,
  output logic        invalid_o,
  output logic [31:0] low_x_o,
  output logic [31:0] low_y_o,
  output logic [31:0] low_z_o,
  output logic [31:0] high_x_o,
  output logic [31:0] high_y_o,
  output logic [31:0] high_z_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_track_bounds_i
);
  import v3n_pkg::*;

  localparam logic [31:0] Len2Min = 32'h322B_CC77;  // 1e-8
  // Squared lengths whose distance from one is within 1e-5.
  localparam logic [31:0] NearLo  = 32'h3F7F_FF59;
  localparam logic [31:0] NearHi  = 32'h3F80_0053;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SQX  = 13'b0000000000010,
    S_SQY  = 13'b0000000000100,
    S_SQZ  = 13'b0000000001000,
    S_ADD1 = 13'b0000000010000,
    S_ADD2 = 13'b0000000100000,
    S_CHK  = 13'b0000001000000,
    S_SQRT = 13'b0000010000000,
    S_RCP  = 13'b0000100000000,
    S_MX   = 13'b0001000000000,
    S_MY   = 13'b0010000000000,
    S_MZ   = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } st_e;

  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic both_zero;
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (both_zero) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  st_e         state_q;
  logic        pend_q;
  logic        track_q;
  logic        first_q;
  logic        bad_q;
  logic [31:0] v_q [3];
  logic [31:0] t0_q, t1_q, t2_q;
  logic [31:0] bnd_lo_q [3];
  logic [31:0] bnd_hi_q [3];
  logic        out_valid_q;
  logic        inv_q;
  logic [31:0] nrm_q [3];
  logic [31:0] lo_q [3];
  logic [31:0] hi_q [3];

  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;
  logic     op_state;

  v3n_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .rsp_o  (fpu_rsp)
  );

  always_comb begin
    fpu_req.op = OP_MUL;
    fpu_req.a  = v_q[0];
    fpu_req.b  = v_q[0];
    op_state   = 1'b1;
    case (state_q)
      S_SQX: begin
        fpu_req.a = v_q[0];
        fpu_req.b = v_q[0];
      end
      S_SQY: begin
        fpu_req.a = v_q[1];
        fpu_req.b = v_q[1];
      end
      S_SQZ: begin
        fpu_req.a = v_q[2];
        fpu_req.b = v_q[2];
      end
      S_ADD1: begin
        fpu_req.op = OP_ADD;
        fpu_req.a  = t0_q;
        fpu_req.b  = t1_q;
      end
      S_ADD2: begin
        fpu_req.op = OP_ADD;
        fpu_req.a  = t0_q;
        fpu_req.b  = t2_q;
      end
      S_SQRT: begin
        fpu_req.op = OP_SQRT;
        fpu_req.a  = t0_q;
      end
      S_RCP: begin
        fpu_req.op = OP_RECIP;
        fpu_req.a  = t1_q;
      end
      S_MX: begin
        fpu_req.a = v_q[0];
        fpu_req.b = t1_q;
      end
      S_MY: begin
        fpu_req.a = v_q[1];
        fpu_req.b = t1_q;
      end
      S_MZ: begin
        fpu_req.a = v_q[2];
        fpu_req.b = t1_q;
      end
      default: op_state = 1'b0;
    endcase
    fpu_req.start = op_state && !pend_q;
  end

  // Length check on the squared length held in t0.
  logic chk_bad, chk_near;
  assign chk_bad  = (t0_q[30:23] == 8'hFF) || (t0_q <= Len2Min);
  assign chk_near = (t0_q >= NearLo) && (t0_q <= NearHi);

  // Bound update for the result in v.
  logic        upd;
  logic        out_wr;
  logic [31:0] lo_new [3];
  logic [31:0] hi_new [3];

  always_comb begin
    upd = !bad_q && track_q;
    for (int c = 0; c < 3; c++) begin
      lo_new[c] = (upd && (first_q || fp_lt(v_q[c], bnd_lo_q[c]))) ? v_q[c] : bnd_lo_q[c];
      hi_new[c] = (upd && (first_q || fp_lt(bnd_hi_q[c], v_q[c]))) ? v_q[c] : bnd_hi_q[c];
    end
  end

  assign out_wr = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      track_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        bnd_lo_q[c] <= 32'd0;
        bnd_hi_q[c] <= 32'd0;
      end
    end else begin
      if (cfg_valid_i) begin
        track_q <= cfg_track_bounds_i;
      end
      if (fpu_req.start) begin
        pend_q <= 1'b1;
      end else if (fpu_rsp.done) begin
        pend_q <= 1'b0;
      end
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_SQX;
        S_SQX:  if (fpu_rsp.done) state_q <= S_SQY;
        S_SQY:  if (fpu_rsp.done) state_q <= S_SQZ;
        S_SQZ:  if (fpu_rsp.done) state_q <= S_ADD1;
        S_ADD1: if (fpu_rsp.done) state_q <= S_ADD2;
        S_ADD2: if (fpu_rsp.done) state_q <= S_CHK;
        S_CHK:  state_q <= (chk_bad || chk_near) ? S_OUT : S_SQRT;
        S_SQRT: if (fpu_rsp.done) state_q <= S_RCP;
        S_RCP:  if (fpu_rsp.done) state_q <= S_MX;
        S_MX:   if (fpu_rsp.done) state_q <= S_MY;
        S_MY:   if (fpu_rsp.done) state_q <= S_MZ;
        S_MZ:   if (fpu_rsp.done) state_q <= S_OUT;
        S_OUT: begin
          if (out_wr) begin
            state_q <= S_IDLE;
            for (int c = 0; c < 3; c++) begin
              bnd_lo_q[c] <= lo_new[c];
              bnd_hi_q[c] <= hi_new[c];
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          v_q[0]  <= comp_x_i;
          v_q[1]  <= comp_y_i;
          v_q[2]  <= comp_z_i;
          first_q <= first_item_i;
        end
      end
      S_SQX:  if (fpu_rsp.done) t0_q <= fpu_rsp.result;
      S_SQY:  if (fpu_rsp.done) t1_q <= fpu_rsp.result;
      S_SQZ:  if (fpu_rsp.done) t2_q <= fpu_rsp.result;
      S_ADD1: if (fpu_rsp.done) t0_q <= fpu_rsp.result;
      S_ADD2: if (fpu_rsp.done) t0_q <= fpu_rsp.result;
      S_CHK:  bad_q <= chk_bad;
      S_SQRT: if (fpu_rsp.done) t1_q <= fpu_rsp.result;
      S_RCP:  if (fpu_rsp.done) t1_q <= fpu_rsp.result;
      S_MX:   if (fpu_rsp.done) v_q[0] <= fpu_rsp.result;
      S_MY:   if (fpu_rsp.done) v_q[1] <= fpu_rsp.result;
      S_MZ:   if (fpu_rsp.done) v_q[2] <= fpu_rsp.result;
      S_OUT: begin
        if (out_wr) begin
          inv_q <= bad_q;
          for (int c = 0; c < 3; c++) begin
            nrm_q[c] <= bad_q ? 32'd0 : v_q[c];
            lo_q[c]  <= lo_new[c];
            hi_q[c]  <= hi_new[c];
          end
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign norm_x_o    = nrm_q[0];
  assign norm_y_o    = nrm_q[1];
  assign norm_z_o    = nrm_q[2];
  assign invalid_o   = inv_q;
  assign low_x_o     = lo_q[0];
  assign low_y_o     = lo_q[1];
  assign low_z_o     = lo_q[2];
  assign high_x_o    = hi_q[0];
  assign high_y_o    = hi_q[1];
  assign high_z_o    = hi_q[2];

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> norm_x_o == 32'd0 && norm_y_o == 32'd0 && norm_z_o == 32'd0)
    else $error("invalid result carries nonzero components");

  a_done_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpu_rsp.done |-> pend_q)
    else $error("arithmetic unit finished without an issued operation");

  a_ready_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_q && !fpu_req.start)
    else $error("input ready while an operation is in flight");

endmodule

[verif/vec3_normalize_minmax_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_normalize_minmax_unit_tb
// Drives float 3-vectors through the normalizer with random idling on both
// sides and checks every result transfer against a bit-exact float predictor.
// ----------------------------------------------------------------------------
module vec3_normalize_minmax_unit_tb;

  localparam logic [31:0] F_ONE     = 32'h3f800000;
  localparam logic [31:0] F_NEG_ONE = 32'hbf800000;
  localparam logic [31:0] F_TWO     = 32'h40000000;
  localparam logic [31:0] F_NEG_TWO = 32'hc0000000;
  localparam logic [31:0] F_FOUR    = 32'h40800000;
  localparam logic [31:0] F_INF     = 32'h7f800000;
  localparam logic [31:0] F_NAN     = 32'h7fc00000;
  localparam logic [31:0] F_MAX     = 32'h7f7fffff;
  localparam logic [31:0] F_MIN_SUB = 32'h00000001;
  localparam logic [31:0] F_NEG_Z   = 32'h80000000;
  localparam logic [31:0] F_TINY_LEN2 = 32'h322bcc77;  // 1e-8 as a float
  localparam logic [31:0] F_UNIT_TOL  = 32'h3727c5ac;  // 1e-5 as a float
  localparam int          LONG_HOLD   = 400;

  typedef struct {
    logic [31:0] norm [3];
    logic        invalid;
    logic [31:0] low  [3];
    logic [31:0] high [3];
  } vec_result_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        first;
    logic        typed;
    logic        invalid;
    logic [31:0] nx, ny, nz;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] comp_x_i = '0, comp_y_i = '0, comp_z_i = '0;
  logic        first_item_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] norm_x_o, norm_y_o, norm_z_o;
  logic        invalid_o;
  logic [31:0] low_x_o, low_y_o, low_z_o, high_x_o, high_y_o, high_z_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_track_bounds_i = 1'b0;

  vec3_normalize_minmax_unit u_dut (.*);

  // Predictor state
  logic [31:0] bnd_low [3];
  logic [31:0] bnd_high [3];
  logic        track_on;
  vec_result_t pending_results [$];
  int          errors;
  bit          no_idle;
  bit          hold_req;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic real f32_to_real(logic [31:0] b);
    logic [10:0] e;
    real         r;
    e = {3'b0, b[30:23]};
    if (b[30:23] == 8'hff) return $bitstoreal({b[31], 11'h7ff, b[22:0], 29'b0});
    if (b[30:23] == 8'h00) begin
      r = real'(b[22:0]) * $bitstoreal({1'b0, 11'(1023 - 149), 52'b0});
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], e + 11'd896, b[22:0], 29'b0});
  endfunction

  // Round a double to single precision, nearest even, subnormals included.
  function automatic logic [31:0] real_to_f32(real r);
    logic [63:0] d, m, q, rem, half;
    int          ex, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7ff) return (d[51:0] != 0) ? F_NAN : {d[63], 8'hff, 23'b0};
    if (d[62:52] == 11'h000) return {d[63], 31'b0};
    ex = int'(d[62:52]) - 1023;
    if (ex > 127) return {d[63], 8'hff, 23'b0};
    m  = {11'b0, 1'b1, d[51:0]};
    sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh > 60) return {d[63], 31'b0};
    q    = m >> sh;
    rem  = m & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (ex < -126) return {d[63], q[30:0]};
    if (q == (64'd1 << 24)) begin
      q = q >> 1;
      ex++;
    end
    if (ex > 127) return {d[63], 8'hff, 23'b0};
    return {d[63], 8'(ex + 127), q[22:0]};
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  // Squared length, validity, optional scaling and bound update for one vector.
  function automatic vec_result_t normalize_vector(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z, logic first);
    vec_result_t res;
    logic [31:0] v [3];
    logic [31:0] len2, diff, root, inv;
    logic        bad;
    real         vr;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    len2 = fadd(fadd(fmul(x, x), fmul(y, y)), fmul(z, z));
    bad  = (len2[30:23] == 8'hff) || (f32_to_real(len2) <= f32_to_real(F_TINY_LEN2));
    if (!bad) begin
      diff = fadd(len2, F_NEG_ONE);
      diff[31] = 1'b0;
      if (f32_to_real(diff) > f32_to_real(F_UNIT_TOL)) begin
        // Double sqrt and divide round correctly to float after a second rounding.
        root = real_to_f32($sqrt(f32_to_real(len2)));
        inv  = real_to_f32(1.0 / f32_to_real(root));
        for (int c = 0; c < 3; c++) v[c] = fmul(v[c], inv);
      end
      if (track_on) begin
        for (int c = 0; c < 3; c++) begin
          vr = f32_to_real(v[c]);
          if (first || vr < f32_to_real(bnd_low[c]))  bnd_low[c]  = v[c];
          if (first || vr > f32_to_real(bnd_high[c])) bnd_high[c] = v[c];
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      res.norm[c] = bad ? 32'h0 : v[c];
      res.low[c]  = bnd_low[c];
      res.high[c] = bnd_high[c];
    end
    res.invalid = bad;
    return res;
  endfunction

  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic first,
                             logic typed = 1'b0, logic t_inv = 1'b0,
                             logic [31:0] tx = '0, logic [31:0] ty = '0,
                             logic [31:0] tz = '0);
    vec_result_t res;
    if (!no_idle && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, 17)) @(negedge clk_i);
    in_valid_i   = 1'b1;
    comp_x_i     = x;
    comp_y_i     = y;
    comp_z_i     = z;
    first_item_i = first;
    do @(posedge clk_i); while (!in_ready_o);
    res = normalize_vector(x, y, z, first);
    if (typed) begin
      res.invalid = t_inv;
      res.norm[0] = tx;
      res.norm[1] = ty;
      res.norm[2] = tz;
    end
    pending_results.push_back(res);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_track(logic value);
    wait (pending_results.size() == 0);
    repeat (4) @(negedge clk_i);
    cfg_valid_i        = 1'b1;
    cfg_track_bounds_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    track_on = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_comp();
    logic [31:0] specials [8] = '{32'h0, F_NEG_Z, F_INF, 32'hff800000, F_NAN,
                                  F_MIN_SUB, F_MAX, 32'h00800000};
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: return specials[$urandom_range(0, 7)];
      2: return {1'($urandom), 8'h00, 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_random(int count);
    logic [31:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        // Vectors near unit length exercise the pass-through window.
        x = {1'($urandom), 8'h7f, 23'($urandom_range(0, 200))};
        if ($urandom_range(0, 1)) x = {1'($urandom), 8'h7e, 23'h7fffff - 23'($urandom_range(0, 200))};
        y = $urandom_range(0, 1) ? 32'h0 : {1'($urandom), 8'($urandom_range(90, 110)), 23'($urandom)};
        z = 32'h0;
      end else begin
        x = rand_comp();
        y = rand_comp();
        z = rand_comp();
      end
      send_vector(x, y, z, (i == 0) || ($urandom_range(0, 9) == 0));
    end
  endtask

  stim_row_t directed [] = '{
    '{32'h0,     32'h0,     32'h0,     1'b1, 1'b1, 1'b1, 32'h0, 32'h0, 32'h0},
    '{F_NEG_Z,   F_NEG_Z,   F_NEG_Z,   1'b0, 1'b1, 1'b1, 32'h0, 32'h0, 32'h0},
    '{F_ONE,     32'h0,     32'h0,     1'b0, 1'b1, 1'b0, F_ONE, 32'h0, 32'h0},
    '{F_NAN,     F_ONE,     32'h0,     1'b0, 1'b1, 1'b1, 32'h0, 32'h0, 32'h0},
    '{32'h0,     F_INF,     32'h0,     1'b1, 1'b1, 1'b1, 32'h0, 32'h0, 32'h0},
    '{F_MAX,     32'h0,     32'h0,     1'b0, 1'b1, 1'b1, 32'h0, 32'h0, 32'h0},
    '{F_MIN_SUB, F_MIN_SUB, F_MIN_SUB, 1'b0, 1'b1, 1'b1, 32'h0, 32'h0, 32'h0},
    '{F_TWO,     32'h0,     32'h0,     1'b0, 1'b1, 1'b0, F_ONE, 32'h0, 32'h0},
    '{F_NEG_TWO, 32'h0,     32'h0,     1'b0, 1'b1, 1'b0, F_NEG_ONE, 32'h0, 32'h0},
    '{32'h0,     32'h0,     F_FOUR,    1'b0, 1'b1, 1'b0, 32'h0, 32'h0, F_ONE},
    '{32'h40400000, 32'h40800000, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{32'h3f800010, 32'h0,   32'h0,     1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{32'h3f7fffe0, 32'h0,   32'h0,     1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{32'h38d1b717, 32'h0,   32'h0,     1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{32'h38d1b718, 32'h0,   32'h0,     1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{32'hc2c80000, 32'h3c23d70a, 32'hff7fffff, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{32'hbf13cd3a, 32'h3f13cd3a, 32'hbf13cd3a, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{32'h00800000, 32'h0,   32'h0,     1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0}
  };

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    vec_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result transfer with none expected, actual norm %h %h %h",
                 $realtime, norm_x_o, norm_y_o, norm_z_o);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("norm_x", exp_r.norm[0], norm_x_o);
        check_field("norm_y", exp_r.norm[1], norm_y_o);
        check_field("norm_z", exp_r.norm[2], norm_z_o);
        check_field("invalid", 32'(exp_r.invalid), 32'(invalid_o));
        check_field("low_x", exp_r.low[0], low_x_o);
        check_field("low_y", exp_r.low[1], low_y_o);
        check_field("low_z", exp_r.low[2], low_z_o);
        check_field("high_x", exp_r.high[0], high_x_o);
        check_field("high_y", exp_r.high[1], high_y_o);
        check_field("high_z", exp_r.high[2], high_z_o);
      end
    end
  end

  initial begin
    #8ms;
    $display("vec3_normalize_minmax_unit: mismatch");
    $finish;
  end

  initial begin
    errors   = 0;
    no_idle  = 1'b0;
    hold_req = 1'b0;
    track_on = 1'b0;
    for (int c = 0; c < 3; c++) begin
      bnd_low[c]  = '0;
      bnd_high[c] = '0;
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i])
      send_vector(directed[i].x, directed[i].y, directed[i].z, directed[i].first,
                  directed[i].typed, directed[i].invalid,
                  directed[i].nx, directed[i].ny, directed[i].nz);

    write_track(1'b1);
    foreach (directed[i]) send_vector(directed[i].x, directed[i].y, directed[i].z,
                                      directed[i].first || i == 0);
    send_random(200);
    // Long receiver hold-off while items keep coming, so the input stalls.
    hold_req = 1'b1;
    send_random(30);
    // Let the block drain completely before the next transfer.
    wait (pending_results.size() == 0);
    @(negedge clk_i);
    send_random(250);

    write_track(1'b0);
    send_random(300);
    write_track(1'b1);
    send_random(300);
    write_track(1'b1);
    no_idle = 1'b1;
    send_random(300);

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("vec3_normalize_minmax_unit: match");
    end else begin
      $display("vec3_normalize_minmax_unit: mismatch");
    end
    $finish;
  end

endmodule
